// File: design/single_wire_sensor_frame_decoder_macros.svh
// Assertion macros shared by the frame decoder modules.
// Uses clk_i and rst_ni of the module that expands them; no other dependencies.
`ifndef SINGLE_WIRE_SENSOR_FRAME_DECODER_MACROS_SVH
`define SINGLE_WIRE_SENSOR_FRAME_DECODER_MACROS_SVH

// same-cycle implication
`define SWSD_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SWSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/swsd_pkg.sv
// Package for the single-wire sensor frame decoder: widths, codes, defaults
// and the result request type. No dependencies.
package swsd_pkg;

  localparam int CapW       = 16;
  localparam int ThrW       = 15;
  localparam int ShiftW     = 40;
  localparam int HumW       = 13;
  localparam int TempW      = 13;
  localparam int MagW       = 15;

  localparam int FrameEntriesDef   = 43;
  localparam int SkippedEntriesDef = 2;

  localparam logic [ThrW-1:0] ThreshReset = 15'd110;
  localparam logic [CapW-1:0] ErrCapture  = 16'hFFFF;
  localparam int              SignBit     = 7;

  // x / 10 == (x * 52429) >> 19 for every x below 2^18
  localparam logic [16:0] Recip10    = 17'd52429;
  localparam int          RecipShift = 19;

  typedef enum logic [1:0] {
    StatOk       = 2'd0,
    StatChecksum = 2'd1,
    StatInvalid  = 2'd2
  } swsd_status_e;

  typedef struct packed {
    swsd_status_e     status;
    logic [15:0]      hum_word;
    logic [MagW-1:0]  mag_word;
    logic             neg;
  } swsd_req_t;

endpackage

// File: design/swsd_frame.sv
// Frame tracker: entry counter, edge-to-edge bit slicer, shift register and
// checksum. Depends on swsd_pkg and the decoder macro header.
`include "single_wire_sensor_frame_decoder_macros.svh"

module swsd_frame #(
  parameter int FRAME_ENTRIES   = swsd_pkg::FrameEntriesDef,
  parameter int SKIPPED_ENTRIES = swsd_pkg::SkippedEntriesDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [swsd_pkg::CapW-1:0]  capture_time_i,
  input  logic                       frame_start_i,
  input  logic [swsd_pkg::ThrW-1:0]  threshold_i,
  output logic                       req_valid_o,
  output swsd_pkg::swsd_req_t        req_o
);
  import swsd_pkg::*;

  localparam int CntW = $clog2(FRAME_ENTRIES);
  localparam logic [CntW-1:0] LastIdx = CntW'(FRAME_ENTRIES - 1);

  logic [CntW-1:0]   cnt_q, cnt_d, cnt_eff;
  logic              active_q, active_d, active_eff;
  logic [CapW-1:0]   prev_q, prev_d;
  logic [ShiftW-1:0] shift_q, shift_d, shift_eff, shift_nxt;
  logic [CapW-1:0]   diff;
  logic              bit_val;
  logic              data_idx;
  logic [7:0]        b0, b1, b2, b3, b4, sum;

  assign active_eff = frame_start_i | active_q;
  assign cnt_eff    = frame_start_i ? '0 : cnt_q;
  assign shift_eff  = frame_start_i ? '0 : shift_q;

  // negative differences never count as a one
  assign diff     = capture_time_i - prev_q;
  assign bit_val  = !diff[CapW-1] && (diff[ThrW-1:0] >= threshold_i);
  assign data_idx = {{(32-CntW){1'b0}}, cnt_eff} > 32'(SKIPPED_ENTRIES);

  // shift register after this capture, when it is a data entry
  assign shift_nxt = data_idx ? {shift_eff[ShiftW-2:0], bit_val} : shift_eff;

  assign b0  = shift_nxt[39:32];
  assign b1  = shift_nxt[31:24];
  assign b2  = shift_nxt[23:16];
  assign b3  = shift_nxt[15:8];
  assign b4  = shift_nxt[7:0];
  assign sum = b0 + b1 + b2 + b3;

  always_comb begin
    cnt_d       = cnt_q;
    active_d    = active_q;
    prev_d      = prev_q;
    shift_d     = shift_q;
    req_valid_o = 1'b0;
    req_o       = '{status: StatOk, hum_word: '0, mag_word: '0, neg: 1'b0};
    if (accept_i && active_eff) begin
      active_d = 1'b1;
      cnt_d    = cnt_eff;
      shift_d  = shift_eff;
      if (capture_time_i == ErrCapture) begin
        active_d     = 1'b0;
        cnt_d        = '0;
        req_valid_o  = 1'b1;
        req_o.status = StatInvalid;
      end else begin
        shift_d = shift_nxt;
        prev_d  = capture_time_i;
        if (cnt_eff == LastIdx) begin
          active_d    = 1'b0;
          cnt_d       = '0;
          req_valid_o = 1'b1;
          if (sum != b4) begin
            req_o.status = StatChecksum;
          end else begin
            req_o.hum_word = {b0, b1};
            req_o.mag_word = {b2[SignBit-1:0], b3};
            req_o.neg      = b2[SignBit];
          end
        end else begin
          cnt_d = cnt_eff + CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      active_q <= 1'b0;
      prev_q   <= '0;
      shift_q  <= '0;
    end else begin
      cnt_q    <= cnt_d;
      active_q <= active_d;
      prev_q   <= prev_d;
      shift_q  <= shift_d;
    end
  end

  `SWSD_ASSERT(a_cnt_range, 1'b1, cnt_q <= LastIdx, "entry count past frame end")
  `SWSD_ASSERT(a_idle_cnt, !active_q, cnt_q == '0, "entry count nonzero while idle")
  `SWSD_ASSERT_NEXT(a_err_ends, accept_i && active_eff && capture_time_i == ErrCapture,
    !active_q && cnt_q == '0, "error capture did not end the frame")

endmodule

// File: design/swsd_scale.sv
// Result path: pending request register, divide-by-ten by reciprocal and the
// output register. Depends on swsd_pkg and the decoder macro header.
`include "single_wire_sensor_frame_decoder_macros.svh"

module swsd_scale (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               req_valid_i,
  input  swsd_pkg::swsd_req_t                req_i,
  output logic                               full_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [swsd_pkg::HumW-1:0]          humidity_o,
  output logic signed [swsd_pkg::TempW-1:0]  temperature_o,
  output logic [1:0]                         status_o
);
  import swsd_pkg::*;

  swsd_req_t                p_q;
  logic                     p_valid_q, p_valid_d;
  logic                     o_valid_q, o_valid_d;
  logic                     p_move;
  logic [32:0]              hum_prod;
  logic [31:0]              mag_prod;
  logic [HumW-1:0]          hum_div;
  logic signed [TempW-1:0]  mag_div;
  logic [HumW-1:0]          hum_q;
  logic signed [TempW-1:0]  temp_q;
  swsd_status_e             status_q;

  assign p_move = p_valid_q && (!o_valid_q || !out_stall_i);
  assign full_o = p_valid_q && !p_move;

  assign hum_prod = 33'(p_q.hum_word) * 33'(Recip10);
  assign mag_prod = 32'(p_q.mag_word) * 32'(Recip10);
  assign hum_div  = hum_prod[RecipShift +: HumW];
  assign mag_div  = {1'b0, mag_prod[RecipShift +: TempW-1]};

  always_comb begin
    p_valid_d = p_valid_q;
    if (req_valid_i) begin
      p_valid_d = 1'b1;
    end else if (p_move) begin
      p_valid_d = 1'b0;
    end
    o_valid_d = o_valid_q;
    if (p_move) begin
      o_valid_d = 1'b1;
    end else if (o_valid_q && !out_stall_i) begin
      o_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      p_valid_q <= p_valid_d;
      o_valid_q <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i) begin
      p_q <= req_i;
    end
    if (p_move) begin
      hum_q    <= hum_div;
      temp_q   <= p_q.neg ? -mag_div : mag_div;
      status_q <= p_q.status;
    end
  end

  assign out_valid_o   = o_valid_q;
  assign humidity_o    = hum_q;
  assign temperature_o = temp_q;
  assign status_o      = status_q;

  `SWSD_ASSERT_NEXT(a_p_advances, p_valid_q && !o_valid_q, o_valid_q,
    "pending result did not reach output")
  `SWSD_ASSERT(a_full_cause, full_o, p_valid_q && o_valid_q && out_stall_i,
    "input stalled without a full result path")
  `SWSD_ASSERT(a_err_zero, o_valid_q && status_q != StatOk,
    hum_q == '0 && temp_q == '0, "failed frame carries nonzero readings")

endmodule

// File: design/single_wire_sensor_frame_decoder.sv
// Top level of the single-wire sensor frame decoder.
// Depends on swsd_pkg, swsd_frame and swsd_scale.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------------
//  in       | in_valid_i / in_stall_o   | capture_time_i[15:0], frame_start_i
//  out      | out_valid_o / out_stall_i | humidity_o, temperature_o, status_o
//  cfg      | cfg_we_i                  | cfg_wdata_i[14:0] (bit threshold)
//
// One capture is taken every cycle unless in_stall_o is high; frame state
// updates at the accepting edge. A finished frame lands in the pending register
// at that edge and moves to the output register, divided by ten by reciprocal
// multiply, once that register is empty or its result is being taken.
// in_stall_o rises only when both the pending and output registers hold
// results and the output is stalled. Reset clears all control state and sets
// the threshold to 110; no clearing pass is needed.
module single_wire_sensor_frame_decoder #(
  parameter int FRAME_ENTRIES   = swsd_pkg::FrameEntriesDef,
  parameter int SKIPPED_ENTRIES = swsd_pkg::SkippedEntriesDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [swsd_pkg::CapW-1:0]          capture_time_i,
  input  logic                               frame_start_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [swsd_pkg::HumW-1:0]          humidity_o,
  output logic signed [swsd_pkg::TempW-1:0]  temperature_o,
  output logic [1:0]                         status_o,
  input  logic                               cfg_we_i,
  input  logic [swsd_pkg::ThrW-1:0]          cfg_wdata_i
);
  import swsd_pkg::*;

  logic [ThrW-1:0] thr_q;
  logic            accept;
  logic            req_valid;
  swsd_req_t       req;
  logic            full;

  // threshold register; the user must write it only while idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThreshReset;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  swsd_frame #(
    .FRAME_ENTRIES  (FRAME_ENTRIES),
    .SKIPPED_ENTRIES(SKIPPED_ENTRIES)
  ) u_frame (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .capture_time_i(capture_time_i),
    .frame_start_i (frame_start_i),
    .threshold_i   (thr_q),
    .req_valid_o   (req_valid),
    .req_o         (req)
  );

  swsd_scale u_scale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_valid),
    .req_i        (req),
    .full_o       (full),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .humidity_o   (humidity_o),
    .temperature_o(temperature_o),
    .status_o     (status_o)
  );

endmodule

// File: bench/tb_single_wire_sensor_frame_decoder.sv
// Testbench for single_wire_sensor_frame_decoder: frame, error and threshold
// checks against a built-in decoder model. Depends on swsd_pkg and the RTL.
module tb_single_wire_sensor_frame_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import swsd_pkg::*;

  localparam int FrameEntries = FrameEntriesDef;
  localparam int SkipEntries  = SkippedEntriesDef;
  // data bits per frame: entry SkipEntries is only remembered
  localparam int DataBits     = FrameEntries - SkipEntries - 1;
  localparam int ItemTarget   = 1800;
  localparam int CycleLimit   = 1000000;
  // wait for the result path to settle after the last capture
  localparam int SettleCycles = 4;
  localparam logic [ThrW-1:0] ThreshMax = '1;

  typedef struct packed {
    logic [HumW-1:0]         humidity;
    logic signed [TempW-1:0] temperature;
    swsd_status_e            status;
  } reading_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [CapW-1:0]         capture_time_i = '0;
  logic                    frame_start_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [HumW-1:0]         humidity_o;
  logic signed [TempW-1:0] temperature_o;
  logic [1:0]              status_o;
  logic                    cfg_we_i = 1'b0;
  logic [ThrW-1:0]         cfg_wdata_i = ThreshReset;

  single_wire_sensor_frame_decoder #(
    .FRAME_ENTRIES  (FrameEntries),
    .SKIPPED_ENTRIES(SkipEntries)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .capture_time_i(capture_time_i),
    .frame_start_i (frame_start_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .humidity_o    (humidity_o),
    .temperature_o (temperature_o),
    .status_o      (status_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // 8 ns period
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // Decoder model: mirror of threshold and frame state, updated once per
  // accepted capture request. Readings it predicts wait in expected_readings.
  // ---------------------------------------------------------------------------
  reading_t        expected_readings[$];
  logic [ThrW-1:0] cur_threshold;
  logic            frm_active;
  int unsigned     frm_index;
  logic [CapW-1:0] frm_prev;
  logic [ShiftW-1:0] frm_bits;

  int fail_count     = 0;
  int accepted_items = 0;  // captures that the block acted on
  int results_seen   = 0;
  int cycle_count    = 0;

  // pacing knobs for sender and receiver
  bit sender_calm   = 1'b0;
  bit receiver_calm = 1'b0;
  int hold_request  = 0;

  // Checksum test and scaling of the five decoded bytes.
  function automatic reading_t reading_from_bits(logic [ShiftW-1:0] bits);
    logic [7:0] b0, b1, b2, b3, b4, sum;
    int hum, mag;
    reading_t r;
    b0  = bits[39:32];
    b1  = bits[31:24];
    b2  = bits[23:16];
    b3  = bits[15:8];
    b4  = bits[7:0];
    sum = b0 + b1 + b2 + b3;  // wraps at 8 bits
    if (sum != b4) begin
      r.humidity    = '0;
      r.temperature = '0;
      r.status      = StatChecksum;
    end else begin
      hum = int'({b0, b1}) / 10;
      // temperature word is sign-magnitude, sign in the top bit of byte 2
      mag = int'({b2[SignBit-1:0], b3}) / 10;
      r.humidity    = hum[HumW-1:0];
      r.temperature = b2[SignBit] ? TempW'(-mag) : TempW'(mag);
      r.status      = StatOk;
    end
    return r;
  endfunction

  // Returns 1 if the capture was part of a frame (not ignored).
  function automatic bit decode_capture(logic [CapW-1:0] cap, logic start);
    logic [CapW-1:0] diff;
    logic one_bit;
    reading_t r;
    if (start) begin
      // a start always opens a fresh frame, dropping any partial one
      frm_active = 1'b1;
      frm_index  = 0;
      frm_bits   = '0;
    end
    if (!frm_active) return 1'b0;
    if (cap == ErrCapture) begin
      frm_active    = 1'b0;
      frm_index     = 0;
      r.humidity    = '0;
      r.temperature = '0;
      r.status      = StatInvalid;
      expected_readings.push_back(r);
      return 1'b1;
    end
    if (frm_index > SkipEntries) begin
      diff = cap - frm_prev;
      // a negative edge-to-edge difference always reads as zero
      one_bit  = !diff[CapW-1] && (diff >= {1'b0, cur_threshold});
      frm_bits = {frm_bits[ShiftW-2:0], one_bit};
    end
    frm_prev = cap;
    if (frm_index >= FrameEntries - 1) begin
      frm_active = 1'b0;
      frm_index  = 0;
      expected_readings.push_back(reading_from_bits(frm_bits));
    end else begin
      frm_index++;
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Edge-to-edge delta that decodes to the wanted bit at the current
  // threshold; boundary values and negative deltas get extra weight.
  function automatic logic [CapW-1:0] delta_for_bit(logic one);
    int thr, hi, lo, r;
    thr = cur_threshold;
    r   = $urandom_range(0, 7);
    if (one) begin
      if (r == 0) return CapW'(thr);
      if (r == 1) return CapW'(32767);
      hi = (thr + 200 > 32767) ? 32767 : thr + 200;
      return CapW'($urandom_range(hi, thr));
    end
    if (thr == 0 || r == 0) return CapW'($urandom_range(65535, 32768));
    if (r == 1) return CapW'(thr - 1);
    if (r == 2) return '0;
    lo = (thr > 200) ? thr - 200 : 0;
    return CapW'($urandom_range(thr - 1, lo));
  endfunction

  function automatic logic [ShiftW-1:0] sensor_word(logic [15:0] hum, logic [15:0] temp,
                                                    logic [7:0] sum_flip);
    logic [7:0] sum;
    sum = hum[15:8] + hum[7:0] + temp[15:8] + temp[7:0];
    return {hum, temp, sum ^ sum_flip};
  endfunction

  // Mostly good checksums, some corrupted, some raw noise.
  function automatic logic [ShiftW-1:0] random_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return {8'($urandom), 32'($urandom)};
    if (r == 1) return sensor_word(16'($urandom), 16'($urandom), 8'($urandom_range(1, 255)));
    return sensor_word(16'($urandom), 16'($urandom), 8'h00);
  endfunction

  function automatic logic [ThrW-1:0] pick_threshold();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return ThreshMax;
    if (r < 7) return ThrW'($urandom_range(300, 40));
    return ThrW'($urandom_range(32767, 0));
  endfunction

  logic [CapW-1:0] frame_caps [FrameEntries];

  // Timer captures for a frame that carries the given bits.
  task automatic fill_frame(input logic [ShiftW-1:0] bits);
    logic [CapW-1:0] t;
    t = CapW'($urandom);
    frame_caps[0] = t;
    for (int i = 1; i < FrameEntries; i++) begin
      if (i <= SkipEntries) t += CapW'($urandom);
      else t += delta_for_bit(bits[DataBits - 1 - (i - SkipEntries - 1)]);
      frame_caps[i] = t;
    end
  endtask

  // One capture request; holds it until accepted, then updates the model.
  task automatic send_capture(input logic [CapW-1:0] cap, input logic start);
    int gap;
    gap = pick_gap(sender_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    capture_time_i <= cap;
    frame_start_i  <= start;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    if (decode_capture(cap, start)) accepted_items++;
  endtask

  // Sends the first stop_at entries of a frame; entry err_at becomes the
  // error capture (negative: none).
  task automatic send_frame(input logic [ShiftW-1:0] bits, input int stop_at,
                            input int err_at);
    fill_frame(bits);
    for (int i = 0; i < stop_at; i++) begin
      send_capture((i == err_at) ? ErrCapture : frame_caps[i], i == 0);
    end
  endtask

  task automatic send_noise(input int count);
    for (int i = 0; i < count; i++) begin
      send_capture(($urandom_range(0, 9) == 0) ? ErrCapture : CapW'($urandom),
                   $urandom_range(0, 7) == 0);
    end
  endtask

  // Input idle until every predicted reading has been taken.
  task automatic await_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_readings.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_threshold(input logic [ThrW-1:0] value);
    await_drained();
    // captures that made no reading may still be in the pipe
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    cur_threshold  = value;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Outside a frame nothing, not even the error capture, makes a reading.
  task automatic test_ignored_without_frame();
    send_capture(16'h0000, 1'b0);
    send_capture(ErrCapture, 1'b0);
    send_capture(16'h8000, 1'b0);
    send_capture(CapW'($urandom), 1'b0);
    await_drained();
  endtask

  task automatic test_invalid_capture();
    send_capture(ErrCapture, 1'b1);           // error on entry zero
    send_capture(16'h1234, 1'b0);             // frame closed: ignored
    send_frame(random_word(), FrameEntries, $urandom_range(FrameEntries - 2, 1));
    send_frame(random_word(), FrameEntries, FrameEntries - 1);
    await_drained();
  endtask

  // A start in the middle of a frame drops it without a reading.
  task automatic test_restart_abandons();
    send_frame(random_word(), 20, -1);
    send_frame(random_word(), 1, -1);
    send_frame(random_word(), FrameEntries - 1, -1);
    send_frame(random_word(), FrameEntries, -1);
    await_drained();
  endtask

  // Runs at the reset threshold, so it also checks the reset value.
  task automatic test_extreme_readings();
    send_frame(sensor_word(16'h0000, 16'h0000, 8'h00), FrameEntries, -1);
    send_frame(sensor_word(16'hFFFF, 16'hFFFF, 8'h00), FrameEntries, -1);
    send_frame(sensor_word(16'hFFFF, 16'h7FFF, 8'h00), FrameEntries, -1);
    send_frame(sensor_word(16'h0009, 16'h8009, 8'h00), FrameEntries, -1);  // minus zero
    send_frame(sensor_word(16'($urandom), 16'($urandom), 8'h01), FrameEntries, -1);
    send_frame({ShiftW{1'b1}}, FrameEntries, -1);  // bad checksum
    await_drained();
  endtask

  task automatic test_threshold_extremes();
    logic [ThrW-1:0] levels [5];
    levels[0] = '0;
    levels[1] = ThreshMax;
    levels[2] = 15'd1;
    levels[3] = pick_threshold();
    levels[4] = ThreshReset;
    foreach (levels[k]) begin
      set_threshold(levels[k]);
      repeat (3) send_frame(random_word(), FrameEntries, -1);
    end
    await_drained();
  endtask

  // Receiver holds off while error captures keep coming, so both result
  // registers fill and the input stalls; then the sender waits it out.
  task automatic test_backpressure();
    sender_calm  = 1'b1;
    hold_request = 300;
    repeat (12) send_capture(ErrCapture, 1'b1);
    send_frame(random_word(), FrameEntries, -1);
    sender_calm = 1'b0;
    await_drained();
  endtask

  // Fills the run up to the item count over all tests.
  task automatic test_random_traffic();
    int seq, r;
    seq = 0;
    while (accepted_items < ItemTarget) begin
      if (seq % 10 == 9) set_threshold(pick_threshold());
      // every so often a stretch with no idling on either side
      sender_calm   = (seq % 16) >= 13;
      receiver_calm = sender_calm;
      r = $urandom_range(0, 99);
      if (r < 70) send_frame(random_word(), FrameEntries, -1);
      else if (r < 80) send_frame(random_word(), $urandom_range(FrameEntries - 1, 1), -1);
      else if (r < 88) send_frame(random_word(), FrameEntries,
                                  $urandom_range(FrameEntries - 1, 0));
      else send_noise($urandom_range(10, 1));
      seq++;
    end
    sender_calm   = 1'b0;
    receiver_calm = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: checks each accepted reading request against the oldest
  // prediction, then picks the stall for the next cycle.
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  int free_left  = 0;
  int hold_left  = 0;

  always @(posedge clk_i) begin
    reading_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_readings.size() == 0) begin
        $error("unexpected reading: humidity %0d temperature %0d status %0d",
               humidity_o, temperature_o, status_o);
        fail_count++;
      end else begin
        want = expected_readings.pop_front();
        results_seen++;
        if (humidity_o !== want.humidity) begin
          $error("humidity: expected %0d, got %0d", want.humidity, humidity_o);
          fail_count++;
        end
        if (temperature_o !== want.temperature) begin
          $error("temperature: expected %0d, got %0d", want.temperature, temperature_o);
          fail_count++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          fail_count++;
        end
      end
    end

    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (receiver_calm) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (free_left > 0) begin
      free_left--;
      out_stall_i <= 1'b0;
    end else begin
      free_left  = $urandom_range(12, 0);
      stall_left = pick_gap(1'b0);
      out_stall_i <= 1'b0;
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_single_wire_sensor_frame_decoder: FAIL");
      $finish;
    end
  end

  initial begin
    cur_threshold = ThreshReset;
    frm_active    = 1'b0;
    frm_index     = 0;
    frm_prev      = '0;
    frm_bits      = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_ignored_without_frame();
    test_invalid_capture();
    test_restart_abandons();
    test_extreme_readings();
    test_threshold_extremes();
    test_backpressure();
    test_random_traffic();

    await_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_single_wire_sensor_frame_decoder: PASS");
    end else begin
      $display("tb_single_wire_sensor_frame_decoder: FAIL");
    end
    $finish;
  end

endmodule
